/* sv/rsvc_pkg.sv */
// ----------------------------------------------------------------------------
// rsvc_pkg
// Shared constants, register codes and stage types for the range sample
// validity check.
// ----------------------------------------------------------------------------
package rsvc_pkg;

    // field widths
    localparam int TIME_W  = 64;
    localparam int MM_W    = 18;
    localparam int TILT_W  = 16;
    localparam int ALPHA_W = 16;
    localparam int STALE_W = 24;
    localparam int CONT_W  = 22;
    localparam int HYST_W  = 24;

    // timing constants
    localparam int STUCK_WINDOW_US = 10000000;
    localparam int AGE_CAP_US      = 4000000;

    // age filter arithmetic
    localparam int ALPHA_ONE = 2 ** ALPHA_W;
    localparam int AGE_W     = $clog2(AGE_CAP_US + 1);
    // raw age is clamped to SAT_W bits: any clamped age with nonzero alpha
    // already drives the filter past the cap
    localparam int SAT_W     = AGE_W + ALPHA_W;
    localparam int LO_W      = SAT_W / 2;
    localparam int HI_W      = SAT_W - LO_W;
    localparam int PLO_W     = ALPHA_W + LO_W;
    localparam int PHI_W     = ALPHA_W + HI_W;
    localparam int MUL_W     = AGE_W + ALPHA_W + 1;
    localparam int ACC_W     = SAT_W + ALPHA_W + 1;

    // configuration port
    localparam int NUM_REGS = 8;
    localparam int IDX_W    = $clog2(NUM_REGS);
    localparam int APB_AW   = IDX_W + 2;
    localparam int APB_DW   = 32;

    localparam logic [STALE_W-1:0]       RST_STALE_LIMIT = STALE_W'(400000);
    localparam logic [CONT_W-1:0]        RST_CONT_LIMIT  = CONT_W'(2000000);
    localparam logic [HYST_W-1:0]        RST_HYST        = HYST_W'(1000000);
    localparam logic signed [TILT_W-1:0] RST_MIN_TILT    = TILT_W'(22938);
    localparam logic [MM_W-1:0]          RST_RANGE_MAX   = MM_W'(25000);
    localparam logic [MM_W-1:0]          RST_RANGE_MIN   = MM_W'(100);
    localparam logic [MM_W-1:0]          RST_GND_CLEAR   = MM_W'(100);
    localparam logic [MM_W-1:0]          RST_STUCK_SPRD  = MM_W'(100);

    typedef enum logic [IDX_W-1:0] {
        REG_STALE_LIMIT = 3'd0,
        REG_CONT_LIMIT  = 3'd1,
        REG_QUAL_HYST   = 3'd2,
        REG_MIN_TILT    = 3'd3,
        REG_RANGE_MAX   = 3'd4,
        REG_RANGE_MIN   = 3'd5,
        REG_GND_CLEAR   = 3'd6,
        REG_STUCK_SPRD  = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [STALE_W-1:0]       stale_limit_us;
        logic [CONT_W-1:0]        continuity_limit_us;
        logic [HYST_W-1:0]        quality_hysteresis_us;
        logic signed [TILT_W-1:0] min_tilt_cosine;
        logic [MM_W-1:0]          range_max_mm;
        logic [MM_W-1:0]          range_min_mm;
        logic [MM_W-1:0]          ground_clearance_mm;
        logic [MM_W-1:0]          stuck_spread_mm;
    } t_cfg;

    // raw input item
    typedef struct packed {
        logic [TIME_W-1:0]        now_us;
        logic [TIME_W-1:0]        range_time_us;
        logic [MM_W-1:0]          range_mm;
        logic                     quality_zero;
        logic                     data_ready;
        logic signed [TILT_W-1:0] tilt_cosine;
        logic                     in_air;
        logic [ALPHA_W-1:0]       half_dt;
    } t_item;

    // item after age subtraction and alpha*age partial products
    typedef struct packed {
        logic [TIME_W-1:0]        now_us;
        logic [TIME_W-1:0]        range_time_us;
        logic [MM_W-1:0]          range_mm;
        logic                     quality_zero;
        logic                     data_ready;
        logic signed [TILT_W-1:0] tilt_cosine;
        logic                     in_air;
        logic [ALPHA_W-1:0]       half_dt;
        logic [PLO_W-1:0]         prod_lo;
        logic [PHI_W-1:0]         prod_hi;
        logic                     stale;
    } t_mid;

endpackage

/* sv/rsvc_regs.sv */
// ----------------------------------------------------------------------------
// rsvc_regs
// APB register file holding the limits and thresholds of the checker.
// ----------------------------------------------------------------------------
module rsvc_regs
    import rsvc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx idx;
    logic     wr_en;

    assign idx    = t_reg_idx'(paddr[APB_AW-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.stale_limit_us        <= RST_STALE_LIMIT;
            r_cfg.continuity_limit_us   <= RST_CONT_LIMIT;
            r_cfg.quality_hysteresis_us <= RST_HYST;
            r_cfg.min_tilt_cosine       <= RST_MIN_TILT;
            r_cfg.range_max_mm          <= RST_RANGE_MAX;
            r_cfg.range_min_mm          <= RST_RANGE_MIN;
            r_cfg.ground_clearance_mm   <= RST_GND_CLEAR;
            r_cfg.stuck_spread_mm       <= RST_STUCK_SPRD;
        end else if (wr_en) begin
            unique case (idx)
                REG_STALE_LIMIT: r_cfg.stale_limit_us        <= pwdata[STALE_W-1:0];
                REG_CONT_LIMIT:  r_cfg.continuity_limit_us   <= pwdata[CONT_W-1:0];
                REG_QUAL_HYST:   r_cfg.quality_hysteresis_us <= pwdata[HYST_W-1:0];
                REG_MIN_TILT:    r_cfg.min_tilt_cosine       <= $signed(pwdata[TILT_W-1:0]);
                REG_RANGE_MAX:   r_cfg.range_max_mm          <= pwdata[MM_W-1:0];
                REG_RANGE_MIN:   r_cfg.range_min_mm          <= pwdata[MM_W-1:0];
                REG_GND_CLEAR:   r_cfg.ground_clearance_mm   <= pwdata[MM_W-1:0];
                REG_STUCK_SPRD:  r_cfg.stuck_spread_mm       <= pwdata[MM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_STALE_LIMIT: prdata = APB_DW'(r_cfg.stale_limit_us);
            REG_CONT_LIMIT:  prdata = APB_DW'(r_cfg.continuity_limit_us);
            REG_QUAL_HYST:   prdata = APB_DW'(r_cfg.quality_hysteresis_us);
            REG_MIN_TILT:    prdata = {{(APB_DW-TILT_W){r_cfg.min_tilt_cosine[TILT_W-1]}},
                                       r_cfg.min_tilt_cosine};
            REG_RANGE_MAX:   prdata = APB_DW'(r_cfg.range_max_mm);
            REG_RANGE_MIN:   prdata = APB_DW'(r_cfg.range_min_mm);
            REG_GND_CLEAR:   prdata = APB_DW'(r_cfg.ground_clearance_mm);
            REG_STUCK_SPRD:  prdata = APB_DW'(r_cfg.stuck_spread_mm);
            default:         prdata = '0;
        endcase
    end

endmodule

/* sv/rsvc_front.sv */
// ----------------------------------------------------------------------------
// rsvc_front
// Input register and age stage: sample age, staleness test and the two
// alpha * age partial products for the age filter.
// ----------------------------------------------------------------------------
module rsvc_front
    import rsvc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_stall,
    input  t_item i_item,
    input  t_cfg  i_cfg,
    output logic  o_mid_vld,
    input  logic  i_take,
    output t_mid  o_mid
);

    logic              r_in_vld;
    t_item             r_in;
    logic              r_mid_vld;
    t_mid              r_mid;
    t_mid              n_mid;
    logic              en_in;
    logic              en_mid;
    logic [TIME_W-1:0] age;
    logic [SAT_W-1:0]  sat;

    assign en_mid    = !r_mid_vld || i_take;
    assign en_in     = !r_in_vld || en_mid;
    assign o_stall   = !en_in;
    assign o_mid_vld = r_mid_vld;
    assign o_mid     = r_mid;

    always_comb begin
        age = r_in.now_us - r_in.range_time_us;
        sat = (|age[TIME_W-1:SAT_W]) ? '1 : age[SAT_W-1:0];

        n_mid.now_us        = r_in.now_us;
        n_mid.range_time_us = r_in.range_time_us;
        n_mid.range_mm      = r_in.range_mm;
        n_mid.quality_zero  = r_in.quality_zero;
        n_mid.data_ready    = r_in.data_ready;
        n_mid.tilt_cosine   = r_in.tilt_cosine;
        n_mid.in_air        = r_in.in_air;
        n_mid.half_dt       = r_in.half_dt;
        n_mid.prod_lo       = PLO_W'(r_in.half_dt) * PLO_W'(sat[LO_W-1:0]);
        n_mid.prod_hi       = PHI_W'(r_in.half_dt) * PHI_W'(sat[SAT_W-1:LO_W]);
        n_mid.stale         = age > TIME_W'(i_cfg.stale_limit_us);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_mid_vld <= 1'b0;
        end else begin
            if (en_in) begin
                r_in_vld <= i_valid;
            end
            if (en_mid) begin
                r_mid_vld <= r_in_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_in && i_valid) begin
            r_in <= i_item;
        end
        if (en_mid && r_in_vld) begin
            r_mid <= n_mid;
        end
    end

endmodule

/* sv/rsvc_core.sv */
// ----------------------------------------------------------------------------
// rsvc_core
// Checker state and result register: age filter update, the ordered
// validity checks, stuck window tracking and ground clearance substitution.
// ----------------------------------------------------------------------------
module rsvc_core
    import rsvc_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_cfg            i_cfg,
    input  logic            i_mid_vld,
    output logic            o_take,
    input  t_mid            i_mid,
    output logic            o_valid,
    input  logic            i_stall,
    output logic            o_range_valid,
    output logic            o_range_stuck,
    output logic [MM_W-1:0] o_range_out_mm
);

    // state
    logic [AGE_W-1:0]  r_filt_age;
    logic              r_valid_flag;
    logic              r_stuck_flag;
    logic [TIME_W-1:0] r_bad_q_time;
    logic [TIME_W-1:0] r_win_start;
    logic [MM_W-1:0]   r_stuck_lo;
    logic [MM_W-1:0]   r_stuck_hi;

    logic [AGE_W-1:0]  n_filt_age;
    logic              n_valid_flag;
    logic              n_stuck_flag;
    logic [TIME_W-1:0] n_bad_q_time;
    logic [TIME_W-1:0] n_win_start;
    logic [MM_W-1:0]   n_stuck_lo;
    logic [MM_W-1:0]   n_stuck_hi;
    logic [MM_W-1:0]   n_range_out;

    // result register
    logic              r_out_vld;
    logic              r_range_valid;
    logic              r_range_stuck;
    logic [MM_W-1:0]   r_range_out;

    logic              en_out;
    logic              mid_fire;
    logic [ALPHA_W:0]  inv_alpha;
    logic [MUL_W-1:0]  decay;
    logic [ACC_W-1:0]  asat;
    logic [ACC_W-1:0]  acc;
    logic [SAT_W:0]    f_raw;
    logic [AGE_W-1:0]  f_cap;
    logic              cont_ok;
    logic              hyst_ok;
    logic              tilt_bad;
    logic              out_range;
    logic              win_over;
    logic              spread_big;
    logic              v;

    assign en_out         = !r_out_vld || !i_stall;
    assign mid_fire       = i_mid_vld && en_out;
    assign o_take         = en_out;
    assign o_valid        = r_out_vld;
    assign o_range_valid  = r_range_valid;
    assign o_range_stuck  = r_range_stuck;
    assign o_range_out_mm = r_range_out;

    // filtered age = (age_f*(1-alpha) + alpha*age + 1/2) >> 16, capped
    always_comb begin
        inv_alpha = (ALPHA_W+1)'(ALPHA_ONE) - {1'b0, i_mid.half_dt};
        decay     = MUL_W'(r_filt_age) * MUL_W'(inv_alpha);
        asat      = ACC_W'({i_mid.prod_hi, LO_W'(0)}) + ACC_W'(i_mid.prod_lo);
        acc       = ACC_W'(decay) + asat + ACC_W'(ALPHA_ONE / 2);
        f_raw     = acc[ACC_W-1:ALPHA_W];
        f_cap     = (f_raw > (SAT_W+1)'(AGE_CAP_US)) ? AGE_W'(AGE_CAP_US)
                                                      : f_raw[AGE_W-1:0];
    end

    always_comb begin
        cont_ok    = 32'(f_cap) < 32'(i_cfg.continuity_limit_us);
        hyst_ok    = (i_mid.now_us - r_bad_q_time) > TIME_W'(i_cfg.quality_hysteresis_us);
        tilt_bad   = $signed(i_mid.tilt_cosine) < $signed(i_cfg.min_tilt_cosine);
        out_range  = (i_mid.range_mm > i_cfg.range_max_mm) ||
                     (i_mid.range_mm < i_cfg.range_min_mm);
        win_over   = (i_mid.range_time_us - r_win_start) > TIME_W'(STUCK_WINDOW_US);
        spread_big = (r_stuck_hi > r_stuck_lo) &&
                     ((r_stuck_hi - r_stuck_lo) > i_cfg.stuck_spread_mm);
    end

    always_comb begin
        n_filt_age   = f_cap;
        n_valid_flag = r_valid_flag;
        n_stuck_flag = r_stuck_flag;
        n_bad_q_time = r_bad_q_time;
        n_win_start  = r_win_start;
        n_stuck_lo   = r_stuck_lo;
        n_stuck_hi   = r_stuck_hi;
        n_range_out  = i_mid.range_mm;
        v            = r_valid_flag;

        if (i_mid.stale) begin
            n_valid_flag = 1'b0;
        end else if ((r_valid_flag || cont_ok) && i_mid.data_ready) begin
            if (i_mid.quality_zero) begin
                n_bad_q_time = i_mid.now_us;
                v            = 1'b0;
            end else if (hyst_ok) begin
                v = 1'b1;
            end

            if (tilt_bad) begin
                v = 1'b0;
            end else if (out_range) begin
                // on the ground the clearance stands in for the sample
                if (i_mid.in_air) begin
                    v = 1'b0;
                end else begin
                    n_range_out = i_cfg.ground_clearance_mm;
                end
            end else begin
                if (win_over && i_mid.in_air) begin
                    if (spread_big) begin
                        n_win_start  = i_mid.range_time_us;
                        n_stuck_lo   = '0;
                        n_stuck_hi   = '0;
                        n_stuck_flag = 1'b0;
                    end else begin
                        if (i_mid.range_mm > r_stuck_hi) begin
                            n_stuck_hi = i_mid.range_mm;
                        end
                        if ((r_stuck_lo == '0) || (i_mid.range_mm < r_stuck_lo)) begin
                            n_stuck_lo = i_mid.range_mm;
                        end
                        n_stuck_flag = 1'b1;
                    end
                end else begin
                    n_win_start = i_mid.range_time_us;
                end
                v = v && !n_stuck_flag;
            end
            n_valid_flag = v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filt_age   <= '0;
            r_valid_flag <= 1'b0;
            r_stuck_flag <= 1'b0;
            r_bad_q_time <= '0;
            r_win_start  <= '0;
            r_stuck_lo   <= '0;
            r_stuck_hi   <= '0;
            r_out_vld    <= 1'b0;
        end else begin
            if (mid_fire) begin
                r_filt_age   <= n_filt_age;
                r_valid_flag <= n_valid_flag;
                r_stuck_flag <= n_stuck_flag;
                r_bad_q_time <= n_bad_q_time;
                r_win_start  <= n_win_start;
                r_stuck_lo   <= n_stuck_lo;
                r_stuck_hi   <= n_stuck_hi;
            end
            if (en_out) begin
                r_out_vld <= i_mid_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mid_fire) begin
            r_range_valid <= n_valid_flag;
            r_range_stuck <= n_stuck_flag;
            r_range_out   <= n_range_out;
        end
    end

    a_age_capped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_filt_age <= AGE_W'(AGE_CAP_US))
        else $error("filtered age above cap");

    a_stale_drops_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mid_fire && i_mid.stale) |=> (!r_valid_flag && !o_range_valid))
        else $error("stale item left validity set");

    a_window_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stuck_lo <= r_stuck_hi)
        else $error("stuck window low above high");

    a_state_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !mid_fire |=> ($stable(r_filt_age) && $stable(r_bad_q_time) &&
                       $stable(r_win_start)))
        else $error("checker state moved without an item");

endmodule

/* sv/range_sample_validity_check.sv */
// ----------------------------------------------------------------------------
// range_sample_validity_check
// Range sample validity and stuck detection for a height estimator.
// ----------------------------------------------------------------------------
// Input channel: i_valid / o_stall with one estimator update per item.
// Output channel: o_valid / i_stall with one result item per input item
// (validity flag, stuck flag, distance after ground substitution).
// Limits and thresholds are set over the APB port, 32-bit registers at
// byte addresses 4*n; write them only while no item is in flight.
// An accepted item passes the input register and the age/product register
// into the result register, which raises o_valid. Throughput: one item per
// cycle while the receiver does not stall; the age filter and state update
// close within the result stage.
// A stalled receiver holds the result register; the two stages in front
// keep taking items until they are full, then o_stall rises.
// Reset (synchronous, active low) empties the pipeline, clears the filter,
// flags, timestamps and stuck window, and loads the default limits.
// ----------------------------------------------------------------------------
module range_sample_validity_check
    import rsvc_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [TIME_W-1:0]        i_now_us,
    input  logic [TIME_W-1:0]        i_range_time_us,
    input  logic [MM_W-1:0]          i_range_mm,
    input  logic                     i_quality_zero,
    input  logic                     i_data_ready,
    input  logic signed [TILT_W-1:0] i_tilt_cosine,
    input  logic                     i_in_air,
    input  logic [ALPHA_W-1:0]       i_half_dt,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic                     o_range_valid,
    output logic                     o_range_stuck,
    output logic [MM_W-1:0]          o_range_out_mm,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_AW-1:0]        paddr,
    input  logic [APB_DW-1:0]        pwdata,
    output logic [APB_DW-1:0]        prdata,
    output logic                     pready
);

    t_cfg  cfg;
    t_item item;
    t_mid  mid;
    logic  mid_vld;
    logic  take;

    always_comb begin
        item.now_us        = i_now_us;
        item.range_time_us = i_range_time_us;
        item.range_mm      = i_range_mm;
        item.quality_zero  = i_quality_zero;
        item.data_ready    = i_data_ready;
        item.tilt_cosine   = i_tilt_cosine;
        item.in_air        = i_in_air;
        item.half_dt       = i_half_dt;
    end

    rsvc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    rsvc_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_item    (item),
        .i_cfg     (cfg),
        .o_mid_vld (mid_vld),
        .i_take    (take),
        .o_mid     (mid)
    );

    rsvc_core u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (cfg),
        .i_mid_vld      (mid_vld),
        .o_take         (take),
        .i_mid          (mid),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_range_valid  (o_range_valid),
        .o_range_stuck  (o_range_stuck),
        .o_range_out_mm (o_range_out_mm)
    );

endmodule
